FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file u2u_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define U2U_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("u2u assertion failed");

// Next-cycle implication, disabled while reset is high.
`define U2U_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("u2u assertion failed");

`endif

FILE: rtl/u2u_pkg.sv
// Types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; used by every module of the block.
package u2u_pkg;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] CP_SUPP    = 21'h10000;
   localparam logic [20:0] CP_TWO     = 21'h00080;
   localparam logic [20:0] CP_THREE   = 21'h00800;

   typedef enum logic [1:0] {
      LEN_ONE   = 2'd0,
      LEN_TWO   = 2'd1,
      LEN_THREE = 2'd2,
      LEN_FOUR  = 2'd3
   } len_type;

   typedef enum logic [1:0] {
      SEG_FLUSH = 2'b01,
      SEG_MAIN  = 2'b10
   } seg_type;

   typedef struct packed {
      logic        has_flush;
      logic [15:0] flush_unit;
      logic        has_main;
      logic [20:0] cp;
      len_type     len;
   } job_type;

endpackage

FILE: rtl/u2u_if.sv
// Stream interfaces for the code unit input and the byte output.
// No dependencies.
interface u2u_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink (input valid, input code_unit, output ready);
endinterface

interface u2u_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;

   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

FILE: rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder. One code unit in per req item, one UTF-8 byte out per
// rsp item, run_last set on the final byte a unit causes. A high surrogate yields
// nothing until the next unit arrives; a unit yields 0 to 6 bytes, which leave
// the byte port one byte a cycle while rsp_ch.ready holds, and that single-byte
// output sets the sustained rate. Units are taken one a cycle while the job queue
// of QUEUE_DEPTH entries has room.
// Depends on u2u_pkg, u2u_if, u2u_front, u2u_queue and u2u_back.
module utf16_to_utf8_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   u2u_req_if.sink   req_ch,
   u2u_rsp_if.source rsp_ch
);
   import u2u_pkg::*;

   logic    push;
   logic    full;
   logic    q_valid;
   logic    q_pop;
   job_type push_job;
   job_type q_job;

   u2u_front front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .full   (full),
      .push   (push),
      .job    (push_job)
   );

   u2u_queue #(.DEPTH(QUEUE_DEPTH)) queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop_valid (q_valid),
      .pop_job   (q_job),
      .pop       (q_pop)
   );

   u2u_back back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (q_job),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );
endmodule

FILE: rtl/u2u_front.sv
// Front end: accepts code units, pairs surrogates, builds byte jobs.
// Depends on u2u_pkg and u2u_req_if.
module u2u_front (
   input  logic             clock,
   input  logic             reset,
   u2u_req_if.sink          req_ch,
   input  logic             full,
   output logic             push,
   output u2u_pkg::job_type job
);
   import u2u_pkg::*;

   logic        held_valid_ff;
   logic        held_valid_in;
   logic [15:0] held_ff;
   logic [15:0] held_in;
   logic        accept;
   logic        is_high;
   logic        is_low;
   logic [20:0] pair_cp;

   function automatic len_type len_of(input logic [20:0] cp);
      len_type len;
      priority if (cp < CP_TWO) begin
         len = LEN_ONE;
      end else if (cp < CP_THREE) begin
         len = LEN_TWO;
      end else if (cp < CP_SUPP) begin
         len = LEN_THREE;
      end else begin
         len = LEN_FOUR;
      end
      return len;
   endfunction

   assign req_ch.ready = !full;
   assign accept = req_ch.valid && !full;
   assign is_high = (req_ch.code_unit >= HIGH_FIRST) && (req_ch.code_unit <= HIGH_LAST);
   assign is_low = (req_ch.code_unit >= LOW_FIRST) && (req_ch.code_unit <= LOW_LAST);
   assign pair_cp = {1'b0, held_ff[9:0], req_ch.code_unit[9:0]} + CP_SUPP;

   always_comb begin
      job = '0;
      held_in = held_ff;
      held_valid_in = held_valid_ff;
      if (held_valid_ff && is_low) begin
         job.has_main = 1'b1;
         job.cp = pair_cp;
         held_valid_in = 1'b0;
      end else begin
         if (held_valid_ff) begin
            job.has_flush = 1'b1;
            job.flush_unit = held_ff;
            held_valid_in = 1'b0;
         end
         if (is_high) begin
            held_in = req_ch.code_unit;
            held_valid_in = 1'b1;
         end else begin
            job.has_main = 1'b1;
            job.cp = {5'b0, req_ch.code_unit};
         end
      end
      job.len = len_of(job.cp);
      push = accept && (job.has_flush || job.has_main);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end
endmodule

FILE: rtl/u2u_queue.sv
// Short job queue between front end and byte sequencer.
// Depends on u2u_pkg.
module u2u_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  u2u_pkg::job_type push_job,
   output logic             full,
   output logic             pop_valid,
   output u2u_pkg::job_type pop_job,
   input  logic             pop
);
   import u2u_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule

FILE: rtl/u2u_back.sv
// Back end: walks each job byte by byte into the output register.
// Depends on u2u_pkg and u2u_rsp_if.
module u2u_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  u2u_pkg::job_type q_job,
   output logic             q_pop,
   u2u_rsp_if.source        rsp_ch
);
   import u2u_pkg::*;

   logic        active_ff;
   logic        active_in;
   seg_type     seg_ff;
   seg_type     seg_in;
   logic [1:0]  idx_ff;
   logic [1:0]  idx_in;
   job_type     job_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  byte_ff;
   logic [7:0]  byte_in;
   logic        last_ff;
   logic        last_in;
   logic [20:0] seg_cp;
   len_type     seg_len;
   logic        seg_end;
   logic        job_end;
   logic        step;

   function automatic logic [7:0] enc_byte(input logic [20:0] cp, input len_type len,
                                          input logic [1:0] idx);
      logic [7:0] b;
      b = '0;
      unique case (len)
         LEN_ONE: b = {1'b0, cp[6:0]};
         LEN_TWO: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
         LEN_THREE: begin
            unique case (idx)
               2'd0: b = {4'b1110, cp[15:12]};
               2'd1: b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         LEN_FOUR: begin
            unique case (idx)
               2'd0: b = {5'b11110, cp[20:18]};
               2'd1: b = {2'b10, cp[17:12]};
               2'd2: b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: b = '0;
      endcase
      return b;
   endfunction

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.run_last = last_ff;

   always_comb begin
      seg_cp = (seg_ff == SEG_FLUSH) ? {5'b0, job_ff.flush_unit} : job_ff.cp;
      seg_len = (seg_ff == SEG_FLUSH) ? LEN_THREE : job_ff.len;
      seg_end = (idx_ff == 2'(seg_len));
      job_end = seg_end && ((seg_ff == SEG_MAIN) || !job_ff.has_main);
      step = active_ff && (!rsp_valid_ff || rsp_ch.ready);
      q_pop = q_valid && (!active_ff || (step && job_end));

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      byte_in = byte_ff;
      last_in = last_ff;
      active_in = active_ff;
      seg_in = seg_ff;
      idx_in = idx_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         byte_in = enc_byte(seg_cp, seg_len, idx_ff);
         last_in = job_end;
         if (job_end) begin
            active_in = 1'b0;
         end else if (seg_end) begin
            seg_in = SEG_MAIN;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (q_pop) begin
         active_in = 1'b1;
         seg_in = q_job.has_flush ? SEG_FLUSH : SEG_MAIN;
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seg_ff <= SEG_MAIN;
         idx_ff <= 2'd0;
      end else begin
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         seg_ff <= seg_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      if (q_pop) begin
         job_ff <= q_job;
      end
   end
endmodule

FILE: rtl/u2u_checker.sv
// Port-level checks for the UTF-16 to UTF-8 encoder, bound to the top level.
// Depends on assert_macros.svh and utf16_to_utf8_encoder.
`include "assert_macros.svh"

module u2u_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  out_byte,
   input logic        run_last
);
   `U2U_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(out_byte) && $stable(run_last))
   `U2U_ASSERT_NOW(ascii_ends_run, clock, reset, rsp_valid && !out_byte[7], run_last)
   `U2U_ASSERT_NOW(lead_not_last, clock, reset, rsp_valid && (out_byte[7:6] == 2'b11), !run_last)
   `U2U_ASSERT_NOW(no_bad_lead, clock, reset, rsp_valid, out_byte[7:3] != 5'b11111)
endmodule

bind utf16_to_utf8_encoder u2u_checker checker_inst (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_byte  (rsp_ch.out_byte),
   .run_last  (rsp_ch.run_last)
);

FILE: dv/u2u_encoder_checker.sv
// Checker for the UTF-16 to UTF-8 encoder: watches both channels, predicts the
// UTF-8 bytes of every accepted code unit and compares each accepted byte.
// Depends on u2u_pkg and u2u_if.
module u2u_encoder_checker (
   input  logic  clock,
   input  logic  reset,
   u2u_req_if    req_mon,
   u2u_rsp_if    rsp_mon,
   output int    mismatch_count,
   output int    pending_bytes
);
   import u2u_pkg::*;

   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } utf8_byte_type;

   utf8_byte_type expected_bytes[$];
   logic [15:0]   held_high;
   logic          held_valid;
   int            errors;

   function automatic len_type utf8_length(input logic [20:0] cp);
      if (cp < CP_TWO) return LEN_ONE;
      if (cp < CP_THREE) return LEN_TWO;
      if (cp < CP_SUPP) return LEN_THREE;
      return LEN_FOUR;
   endfunction

   function automatic logic [7:0] cont_byte(input logic [5:0] bits);
      return CONT_MARK | {2'b00, bits};
   endfunction

   task automatic push_byte(input logic [7:0] value);
      utf8_byte_type b;
      b.value = value;
      b.last  = 1'b0;
      expected_bytes.push_back(b);
   endtask

   task automatic push_code_point(input logic [20:0] cp);
      case (utf8_length(cp))
         LEN_ONE: begin
            push_byte(cp[7:0]);
         end
         LEN_TWO: begin
            push_byte(LEAD_TWO | {3'b000, cp[10:6]});
            push_byte(cont_byte(cp[5:0]));
         end
         LEN_THREE: begin
            push_byte(LEAD_THREE | {4'b0000, cp[15:12]});
            push_byte(cont_byte(cp[11:6]));
            push_byte(cont_byte(cp[5:0]));
         end
         default: begin
            push_byte(LEAD_FOUR | {5'b00000, cp[20:18]});
            push_byte(cont_byte(cp[17:12]));
            push_byte(cont_byte(cp[11:6]));
            push_byte(cont_byte(cp[5:0]));
         end
      endcase
   endtask

   task automatic predict_unit(input logic [15:0] unit);
      int          start;
      logic        is_high;
      logic        is_low;
      logic [20:0] cp;
      start   = expected_bytes.size();
      is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
      is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
      if (held_valid && is_low) begin
         cp = ((21'(held_high - HIGH_FIRST) & 21'h3FF) << 10)
            + 21'(unit - LOW_FIRST) + CP_SUPP;
         held_valid = 1'b0;
         held_high  = '0;
         push_code_point(cp);
      end else begin
         if (held_valid) begin
            push_code_point(21'(held_high));
            held_valid = 1'b0;
            held_high  = '0;
         end
         if (is_high) begin
            held_high  = unit;
            held_valid = 1'b1;
         end else begin
            push_code_point(21'(unit));
         end
      end
      if (expected_bytes.size() > start)
         expected_bytes[expected_bytes.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      utf8_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         held_high  = '0;
         held_valid = 1'b0;
         errors     = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_unit(req_mon.code_unit);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               $error("out_byte: expected none, got %02h", rsp_mon.out_byte);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_mon.out_byte !== want.value) begin
                  $error("out_byte: expected %02h, got %02h", want.value, rsp_mon.out_byte);
                  errors++;
               end
               if (rsp_mon.run_last !== want.last) begin
                  $error("run_last: expected %0b, got %0b", want.last, rsp_mon.run_last);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_bytes  <= expected_bytes.size();
   end

endmodule

FILE: dv/tb_top.sv
// Top of the UTF-16 to UTF-8 encoder testbench: clock, reset, code unit stimulus,
// random byte port stalls and the verdict; checking lives in u2u_encoder_checker.
// Depends on u2u_pkg, u2u_if, utf16_to_utf8_encoder and u2u_encoder_checker.
module tb_top;
   import u2u_pkg::*;

   localparam int RANDOM_ITEMS = 296;
   localparam int TAIL_CYCLES  = 50;
   localparam int CYCLE_LIMIT  = 800000;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_bytes;
   int   cycle_count;
   logic calm_req;

   logic [15:0] directed_units [24] = '{
      16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF,
      16'hE000, 16'hFFFF, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
      16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF, 16'hD834, 16'h0000,
      16'hDBFF, 16'hFFFF, 16'hDA00, 16'h0041, 16'hD900, 16'h0400
   };

   u2u_req_if req_ch ();
   u2u_rsp_if rsp_ch ();

   utf16_to_utf8_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   u2u_encoder_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_bytes  (pending_bytes)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_unit(input logic [15:0] unit);
      int gap;
      req_ch.valid     <= 1'b1;
      req_ch.code_unit <= unit;
      do @(posedge clock); while (!req_ch.ready);
      gap = calm_req ? 0 : idle_len();
      if (gap > 0) begin
         req_ch.valid     <= 1'b0;
         req_ch.code_unit <= 16'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] three_byte_unit();
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(16'h0800, 16'hD7FF));
      return 16'($urandom_range(16'hE000, 16'hFFFF));
   endfunction

   task automatic send_random_group(output int count);
      int r;
      r     = $urandom_range(0, 99);
      count = 1;
      if (r < 20) begin
         send_unit(16'($urandom_range(1, 16'h007F)));
      end else if (r < 35) begin
         send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (r < 55) begin
         send_unit(three_byte_unit());
      end else if (r < 75) begin
         send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
         send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)));
         count = 2;
      end else if (r < 82) begin
         send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)));
      end else if (r < 88) begin
         send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)));
      end else if (r < 93) begin
         send_unit(16'h0000);
      end else begin
         send_unit(16'($urandom));
      end
   endtask

   initial begin
      int sent;
      int count;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.code_unit <= '0;
      calm_req          = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_units[i])
         send_unit(directed_units[i]);
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 32 == 0)
            calm_req = ($urandom_range(0, 3) == 0);
         send_random_group(count);
         sent += count;
      end
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_bytes != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_bytes == 0) begin
         $display("utf16_to_utf8_encoder test passed");
      end else begin
         $display("utf16_to_utf8_encoder test failed");
      end
      $finish;
   end

   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end else begin
            gap = idle_len();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("utf16_to_utf8_encoder test failed");
      $finish;
   end

endmodule
